@@ rtl/trio_mendel_check_phase_macros.svh @@
// Assertion macros for the trio Mendel check top level.
`ifndef TRIO_MENDEL_CHECK_PHASE_MACROS_SVH
`define TRIO_MENDEL_CHECK_PHASE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tmc_pkg.sv @@
// Shared types and constants for the trio Mendel check and phasing block.
package tmc_pkg;

  localparam int IDX_W       = 16;
  localparam int TOTAL_W     = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Classified locus as it travels from the front to the back.
  typedef struct packed {
    logic [IDX_W-1:0] marker_index;
    logic             mendel_error;
    logic             examined;
    logic             locus_known;
    logic             first_trans_bit;
    logic             second_trans_bit;
    logic             child_trans_bit;
    logic             child_heterozygous;
  } cls_t;

endpackage

@@ rtl/tmc_in_if.sv @@
// Input channel: one trio or duo locus per transfer.
interface tmc_in_if;
  import tmc_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] marker_index;
  logic             is_trio;
  logic             child_homozygous;
  logic             child_allele;
  logic             child_missing;
  logic             first_homozygous;
  logic             first_allele;
  logic             first_missing;
  logic             second_homozygous;
  logic             second_allele;
  logic             second_missing;

  modport source (
    output valid, marker_index, is_trio, child_homozygous, child_allele, child_missing,
           first_homozygous, first_allele, first_missing,
           second_homozygous, second_allele, second_missing,
    input  ready
  );

  modport sink (
    input  valid, marker_index, is_trio, child_homozygous, child_allele, child_missing,
           first_homozygous, first_allele, first_missing,
           second_homozygous, second_allele, second_missing,
    output ready
  );
endinterface

@@ rtl/tmc_out_if.sv @@
// Output channel: one check and phasing result per transfer.
interface tmc_out_if;
  import tmc_pkg::*;

  logic               valid;
  logic               ready;
  logic               mendel_error;
  logic               examined;
  logic               locus_known;
  logic               first_trans_bit;
  logic               second_trans_bit;
  logic               child_trans_bit;
  logic               child_heterozygous;
  logic [TOTAL_W-1:0] error_total;
  logic [TOTAL_W-1:0] examined_total;

  modport source (
    output valid, mendel_error, examined, locus_known, first_trans_bit,
           second_trans_bit, child_trans_bit, child_heterozygous,
           error_total, examined_total,
    input  ready
  );

  modport sink (
    input  valid, mendel_error, examined, locus_known, first_trans_bit,
           second_trans_bit, child_trans_bit, child_heterozygous,
           error_total, examined_total,
    output ready
  );
endinterface

@@ rtl/tmc_front.sv @@
// Front end: accepts a locus, checks Mendelian consistency and derives phase bits.
module tmc_front (
  input  logic         clk,
  input  logic         rst,
  tmc_in_if.sink       in_ch,
  input  logic         hold,
  input  logic         q_full,
  output logic         q_push,
  output tmc_pkg::cls_t q_item
);
  import tmc_pkg::*;

  logic front_valid;
  cls_t front_item;
  cls_t cls;
  logic accept;

  logic ph0, pa0, pm0, ph1, pa1, pm1;
  logic ch, ca, cm, trio;
  logic err;

  always_comb begin
    trio = in_ch.is_trio;
    ch   = in_ch.child_homozygous;
    ca   = in_ch.child_allele;
    cm   = in_ch.child_missing;
    ph0  = in_ch.first_homozygous;
    pa0  = in_ch.first_allele;
    pm0  = in_ch.first_missing;
    // A duo has no second parent: treat it as missing.
    ph1  = trio & in_ch.second_homozygous;
    pa1  = trio & in_ch.second_allele;
    pm1  = ~trio | in_ch.second_missing;

    err = 1'b0;
    if (!cm && (ph0 || ph1)) begin
      if (ph0 && ph1) begin
        if (ch) err = (pa0 ^ pa1) | ((pa0 & pa1) != ca);
        else    err = ~(pa0 ^ pa1);
      end else if (ch) begin
        err = (ph0 ? pa0 : pa1) != ca;
      end
    end

    cls                    = '0;
    cls.marker_index       = in_ch.marker_index;
    cls.mendel_error       = err;
    cls.examined           = ~cm & (~pm0 | ~pm1);
    if (!err) begin
      cls.child_heterozygous = trio & ~ch & ~cm;
      if (ph0 && ph1) begin
        // both parents homozygous: nothing new learned
      end else if (ch) begin
        cls.first_trans_bit  = ca;
        cls.second_trans_bit = trio & ca;
        cls.locus_known      = 1'b1;
      end else if ((!ph0 || pm0) && (!ph1 || pm1)) begin
        // ambiguous
      end else if (!trio) begin
        cls.child_trans_bit = pa0;
        cls.locus_known     = 1'b1;
      end else if (!cm) begin
        // the heterozygous parent passed the allele the homozygous one lacks
        if (ph0) cls.second_trans_bit = ~pa0;
        else     cls.first_trans_bit  = ~pa1;
        cls.locus_known = 1'b1;
      end
    end
  end

  assign in_ch.ready = ~hold & (~front_valid | ~q_full);
  assign accept      = in_ch.valid & in_ch.ready;
  assign q_push      = front_valid & ~q_full;
  assign q_item      = front_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (q_push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item <= cls;
    end
  end
endmodule

@@ rtl/tmc_queue.sv @@
// Short queue of classified loci between the front and the back.
module tmc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tmc_pkg::cls_t push_item,
  output logic          full,
  output logic          head_valid,
  output tmc_pkg::cls_t head_item,
  input  logic          pop
);
  import tmc_pkg::*;

  cls_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end
endmodule

@@ rtl/tmc_back.sv @@
// Back end: per-marker counter read-modify-write with forwarding and result register.
module tmc_back #(
  parameter int MAX_MARKERS = 65536,
  parameter int COUNT_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  tmc_pkg::cls_t head_item,
  output logic          pop,
  output logic          clearing,
  tmc_out_if.source     out_ch
);
  import tmc_pkg::*;

  localparam int ADDR_W = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int EXT_W  = ADDR_W + IDX_W;
  localparam int TEXT_W = COUNT_BITS + TOTAL_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [2*COUNT_BITS-1:0] cnt_mem [MAX_MARKERS];

  logic [ADDR_W-1:0]       clr_addr;
  logic [EXT_W-1:0]        rd_ext;
  logic [ADDR_W-1:0]       rd_addr;
  logic [2*COUNT_BITS-1:0] rd_data;

  logic                    stage_valid;
  cls_t                    stage_item;
  logic [ADDR_W-1:0]       stage_addr;
  logic                    stage_fire;
  logic                    in_range;

  logic                    lw_valid;
  logic [ADDR_W-1:0]       lw_addr;
  logic [2*COUNT_BITS-1:0] lw_data;

  logic [2*COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0]   err_new;
  logic [COUNT_BITS-1:0]   exam_new;
  logic [TEXT_W-1:0]       err_ext;
  logic [TEXT_W-1:0]       exam_ext;

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [2*COUNT_BITS-1:0] wr_data;

  logic                    out_valid;
  cls_t                    out_item;
  logic [TOTAL_W-1:0]      out_err_total;
  logic [TOTAL_W-1:0]      out_exam_total;

  assign rd_ext  = EXT_W'(head_item.marker_index);
  assign rd_addr = rd_ext[ADDR_W-1:0];

  assign stage_fire = stage_valid & (~out_valid | out_ch.ready);
  assign pop        = head_valid & (~stage_valid | stage_fire);
  assign in_range   = 32'(stage_item.marker_index) < 32'(MAX_MARKERS);

  // Take the newest value when the last write hit this marker.
  always_comb begin
    cur      = (lw_valid && lw_addr == stage_addr) ? lw_data : rd_data;
    err_new  = cur[2*COUNT_BITS-1:COUNT_BITS];
    exam_new = cur[COUNT_BITS-1:0];
    if (stage_item.mendel_error && err_new != CNT_MAX) err_new = err_new + 1'b1;
    if (stage_item.examined && exam_new != CNT_MAX)    exam_new = exam_new + 1'b1;
    err_ext  = TEXT_W'(err_new);
    exam_ext = TEXT_W'(exam_new);
  end

  assign wr_en   = clearing | (stage_fire & in_range);
  assign wr_addr = clearing ? clr_addr : stage_addr;
  assign wr_data = clearing ? '0 : {err_new, exam_new};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= cnt_mem[rd_addr];
    end
  end

  // Sweep every counter to zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MAX_MARKERS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      lw_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop)             stage_valid <= 1'b1;
      else if (stage_fire) stage_valid <= 1'b0;
      if (stage_fire && in_range) lw_valid <= 1'b1;
      if (stage_fire)          out_valid <= 1'b1;
      else if (out_ch.ready)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stage_item <= head_item;
      stage_addr <= rd_addr;
    end
    if (stage_fire && in_range) begin
      lw_addr <= stage_addr;
      lw_data <= {err_new, exam_new};
    end
    if (stage_fire) begin
      out_item       <= stage_item;
      out_err_total  <= in_range ? err_ext[TOTAL_W-1:0] : '0;
      out_exam_total <= in_range ? exam_ext[TOTAL_W-1:0] : '0;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.mendel_error       = out_item.mendel_error;
  assign out_ch.examined           = out_item.examined;
  assign out_ch.locus_known        = out_item.locus_known;
  assign out_ch.first_trans_bit    = out_item.first_trans_bit;
  assign out_ch.second_trans_bit   = out_item.second_trans_bit;
  assign out_ch.child_trans_bit    = out_item.child_trans_bit;
  assign out_ch.child_heterozygous = out_item.child_heterozygous;
  assign out_ch.error_total        = out_err_total;
  assign out_ch.examined_total     = out_exam_total;
endmodule

@@ rtl/trio_mendel_check_phase.sv @@
// Trio/duo Mendelian error check and transmitted-allele phasing, one locus per transfer.
// Sustains one locus per cycle while results are taken and no counter sweep runs; each
// locus passes the classifier register, the queue, the counter stage and the output
// register. A result held on the output lets six more loci enter before the input stalls:
// one in the counter stage, four in the queue between the classifier and the counter
// stage, and one in the classifier register. The rate is set by the per-marker counter
// memory, read once and written once per locus, with the last write forwarded so that
// repeated markers back to back count correctly. After reset the counters are swept to
// zero, one address after another, and no locus is accepted during the sweep. Markers at
// or above MAX_MARKERS leave the counters alone and report totals of zero.
`include "trio_mendel_check_phase_macros.svh"

module trio_mendel_check_phase #(
  parameter int MAX_MARKERS = 65536,
  parameter int COUNT_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst,
  tmc_in_if.sink   in_ch,
  tmc_out_if.source out_ch
);
  import tmc_pkg::*;

  logic clearing;
  logic q_full;
  logic q_push;
  cls_t q_item;
  logic head_valid;
  cls_t head_item;
  logic pop;

  tmc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .hold   (clearing),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  tmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  tmc_back #(
    .MAX_MARKERS (MAX_MARKERS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

  `TMC_ASSERT_NOW(a_no_accept_while_clearing, clk, rst,
                  clearing, !in_ch.ready, "locus accepted during counter sweep")
  `TMC_ASSERT_NOW(a_error_clears_phase, clk, rst,
                  out_ch.valid && out_ch.mendel_error,
                  !out_ch.locus_known && !out_ch.first_trans_bit &&
                  !out_ch.second_trans_bit && !out_ch.child_trans_bit &&
                  !out_ch.child_heterozygous,
                  "phase bits set on a Mendelian error")
  `TMC_ASSERT_NOW(a_duo_child_bit, clk, rst,
                  out_ch.valid && out_ch.child_trans_bit,
                  out_ch.locus_known && !out_ch.second_trans_bit &&
                  !out_ch.child_heterozygous,
                  "duo child bit with trio-only bits")
  `TMC_ASSERT_NEXT(a_queue_push_blocked, clk, rst,
                   q_full && !pop, !q_push || q_full, "push into a full queue")
endmodule
